// ===== rtl/bses_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond stretch energy sum: shared package
// Types and fixed constants shared by the front end, the queue and the back
// end of the bond stretch energy accumulator.
// ----------------------------------------------------------------------------
package bses_pkg;

    // Fixed point format, accumulator width, coordinate width and queue depth.
    localparam int FRAC_BITS   = 16;
    localparam int SUM_WIDTH   = 48;
    localparam int COORD_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    // Potential form codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        FORM_QUARTIC = 2'd0,
        FORM_MORSE   = 2'd1,
        FORM_QUAD    = 2'd2,
        FORM_NONE    = 2'd3
    } t_form;

    // One classified bond as it travels from the front end to the back end.
    typedef struct packed {
        logic [COORD_W-1:0]        mag_x;
        logic [COORD_W-1:0]        mag_y;
        logic [COORD_W-1:0]        mag_z;
        t_form                     form;
        logic signed [COORD_W-1:0] ref_length;
        logic signed [COORD_W-1:0] coef_b;
        logic signed [COORD_W-1:0] coef_c;
        logic signed [COORD_W-1:0] coef_d;
        logic                      last_bond;
    } t_job;

endpackage

// ===== rtl/bses_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond stretch energy sum: front end
// Takes a bond transfer, forms the per-axis separation magnitudes, decodes
// the potential form and pushes the classified bond into the queue.
// ----------------------------------------------------------------------------
module bses_front (
    input  logic                                   i_valid,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_first_y,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_first_z,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_second_y,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_second_z,
    input  logic [1:0]                             i_potential_form,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_ref_length,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_coef_b,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_coef_c,
    input  logic signed [bses_pkg::COORD_W-1:0]    i_coef_d,
    input  logic                                   i_last_bond,
    input  logic                                   i_full,
    output logic                                   o_push,
    output bses_pkg::t_job                         o_job
);

    localparam int CW = bses_pkg::COORD_W;

    // Magnitude of a - b; the difference needs one extra bit, its magnitude does not.
    function automatic logic [CW-1:0] sep_mag(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
        logic [CW:0] diff;
        diff = {a[CW-1], a} - {b[CW-1], b};
        return diff[CW] ? CW'(-diff) : diff[CW-1:0];
    endfunction

    always_comb begin
        o_job.mag_x      = sep_mag(i_first_x, i_second_x);
        o_job.mag_y      = sep_mag(i_first_y, i_second_y);
        o_job.mag_z      = sep_mag(i_first_z, i_second_z);
        o_job.form       = bses_pkg::t_form'(i_potential_form);
        o_job.ref_length = i_ref_length;
        o_job.coef_b     = i_coef_b;
        o_job.coef_c     = i_coef_c;
        o_job.coef_d     = i_coef_d;
        o_job.last_bond  = i_last_bond;
    end

    assign o_push = i_valid && !i_full;

endmodule

// ===== rtl/bses_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond stretch energy sum: job queue
// A short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module bses_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bses_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output bses_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam int DEPTH = bses_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    bses_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;
    logic           do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bses_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond stretch energy sum: back end
// Sequencer around one shared 32x32 multiplier: squared separation, bit
// pair square root, fixed point products, exponential series and the
// saturating molecule accumulator with its output register.
// ----------------------------------------------------------------------------
module bses_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_job_valid,
    input  bses_pkg::t_job                        i_job,
    output logic                                  o_job_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [bses_pkg::SUM_WIDTH-1:0] o_energy,
    output logic                                  o_overflow
);

    localparam int SW  = bses_pkg::SUM_WIDTH;
    localparam int F   = bses_pkg::FRAC_BITS;
    localparam int QW  = 128 - F + 1;
    localparam int EW  = 39;
    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] ONE  = SW'(1) << F;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [SW:0] EXP_LIM = (SW+1)'(44) << F;

    typedef enum logic [4:0] {
        B_IDLE, B_SQ_SET, B_SQ_ACC, B_SQRT, B_DEV, B_OP, B_MUL, B_QPOST, B_WB,
        B_EXP_CHK, B_EXP_DIV, B_EXP_FIX, B_EXP_MUL, B_EXP_DSET, B_EXP_DN,
        B_EXP_NEXT, B_EXP_SCALE, B_EXP_U, B_ACC
    } t_state;

    typedef enum logic [2:0] {
        SRC_D, SRC_D2, SRC_D3, SRC_D4, SRC_KB, SRC_KC, SRC_KD
    } t_src;

    typedef enum logic [2:0] {
        DST_D2, DST_D3, DST_D4, DST_TSET, DST_TADD
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        t_dst dst;
        logic last;
    } t_op;

    // Product program of each potential form.
    function automatic t_op prog(input bses_pkg::t_form f, input logic [2:0] s);
        t_op op;
        op = '{SRC_D, SRC_D, DST_D2, 1'b1};
        case (f)
            bses_pkg::FORM_QUARTIC: begin
                case (s)
                    3'd0:    op = '{SRC_D,  SRC_D,  DST_D2,   1'b0};
                    3'd1:    op = '{SRC_D2, SRC_D,  DST_D3,   1'b0};
                    3'd2:    op = '{SRC_D2, SRC_D2, DST_D4,   1'b0};
                    3'd3:    op = '{SRC_KB, SRC_D2, DST_TSET, 1'b0};
                    3'd4:    op = '{SRC_KC, SRC_D3, DST_TADD, 1'b0};
                    default: op = '{SRC_KD, SRC_D4, DST_TADD, 1'b1};
                endcase
            end
            bses_pkg::FORM_MORSE: begin
                case (s)
                    3'd0:    op = '{SRC_KC, SRC_D,  DST_D3,   1'b0};
                    3'd1:    op = '{SRC_D4, SRC_D4, DST_D2,   1'b0};
                    default: op = '{SRC_KB, SRC_D2, DST_TSET, 1'b1};
                endcase
            end
            bses_pkg::FORM_QUAD: begin
                case (s)
                    3'd0:    op = '{SRC_D,  SRC_D,  DST_D2,   1'b0};
                    default: op = '{SRC_KB, SRC_D2, DST_TSET, 1'b1};
                endcase
            end
            default: op = '{SRC_D, SRC_D, DST_D2, 1'b1};
        endcase
        return op;
    endfunction

    // Saturating add; the top bit of the result is the saturation flag.
    function automatic logic [SW:0] sat_add(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            return {1'b1, (s[SW] ? SMIN : SMAX)};
        end
        return {1'b0, s[SW-1:0]};
    endfunction

    function automatic logic [SW-1:0] mag(input logic [SW-1:0] x);
        return x[SW-1] ? SW'(-x) : x;
    endfunction

    t_state                r_state;
    t_state                r_ret;
    bses_pkg::t_job        r_job;
    logic [1:0]            r_sq_idx;
    logic [65:0]           r_rad;
    logic [35:0]           r_rem;
    logic [32:0]           r_root;
    logic [5:0]            r_cnt;
    logic [SW-1:0]         r_d;
    logic [SW-1:0]         r_d2;
    logic [SW-1:0]         r_d3;
    logic [SW-1:0]         r_d4;
    logic [SW-1:0]         r_t;
    logic [SW-1:0]         r_q;
    logic [2:0]            r_step;
    logic                  r_neg;
    logic                  r_sflag;
    logic [SW-1:0]         r_sum;
    logic                  r_sat;
    logic [63:0]           r_ma;
    logic [63:0]           r_mb;
    logic [2:0]            r_mc;
    logic [63:0]           r_pp;
    logic [1:0]            r_pi;
    logic [127:0]          r_acc;
    logic                  r_yneg;
    logic [EW-1:0]         r_rm;
    logic [2:0]            r_qi;
    logic [6:0]            r_qt;
    logic signed [7:0]     r_k;
    logic [31:0]           r_s;
    logic [32:0]           r_term;
    logic [34:0]           r_esum;
    logic [3:0]            r_n;
    logic [31:0]           r_dq;
    logic [3:0]            r_dr;
    logic [SW-1:0]         r_e;
    logic                  r_out_valid;
    logic [SW-1:0]         r_out_energy;
    logic                  r_out_ovf;

    t_op                   cur_op;
    logic [SW-1:0]         op_a;
    logic [SW-1:0]         op_b;
    logic [31:0]           mul_ah;
    logic [31:0]           mul_bh;
    logic [63:0]           mul_pp;
    logic [127:0]          mul_add;
    logic [35:0]           sq_rem_s;
    logic [35:0]           sq_trial;
    logic [34:0]           dev;
    logic [QW-1:0]         qp_q;
    logic [SW-1:0]         qp_res;
    logic                  qp_flag;
    logic [SW:0]           wb_sat;
    logic [SW:0]           acc_sat;
    logic signed [SW:0]    ey;
    logic [SW:0]           ey_mag;
    logic [EW-1:0]         ed_trial;
    logic [4:0]            dn_rs;
    logic                  dn_ge;
    logic signed [7:0]     sc_sh;
    logic [7:0]            sc_nsh;
    logic [63:0]           sc_v;
    logic [SW-1:0]         sc_e;
    logic                  sc_flag;
    logic [31:0]           sq_mag;
    logic                  out_load;

    function automatic logic [SW-1:0] pick(input t_src s, input logic [SW-1:0] d,
                                           input logic [SW-1:0] d2,
                                           input logic [SW-1:0] d3,
                                           input logic [SW-1:0] d4,
                                           input bses_pkg::t_job j);
        case (s)
            SRC_D:   return d;
            SRC_D2:  return d2;
            SRC_D3:  return d3;
            SRC_D4:  return d4;
            SRC_KB:  return SW'(j.coef_b);
            SRC_KC:  return SW'(j.coef_c);
            default: return SW'(j.coef_d);
        endcase
    endfunction

    always_comb begin
        cur_op = prog(r_job.form, r_step);
        op_a   = pick(cur_op.a, r_d, r_d2, r_d3, r_d4, r_job);
        op_b   = pick(cur_op.b, r_d, r_d2, r_d3, r_d4, r_job);

        case (r_sq_idx)
            2'd0:    sq_mag = r_job.mag_x;
            2'd1:    sq_mag = r_job.mag_y;
            default: sq_mag = r_job.mag_z;
        endcase

        // Shared multiplier: one 32x32 partial product per cycle.
        mul_ah = r_mc[0] ? r_ma[63:32] : r_ma[31:0];
        mul_bh = r_mc[1] ? r_mb[63:32] : r_mb[31:0];
        mul_pp = mul_ah * mul_bh;
        case (r_pi)
            2'd0:    mul_add = {64'b0, r_pp};
            2'd3:    mul_add = {r_pp, 64'b0};
            default: mul_add = {32'b0, r_pp, 32'b0};
        endcase

        // One result bit of the square root per cycle.
        sq_rem_s = {r_rem[33:0], r_rad[65:64]};
        sq_trial = {1'b0, r_root, 2'b01};

        dev = {2'b00, r_root} - {{3{r_job.ref_length[31]}}, r_job.ref_length};

        // Product scaling: floor of the signed product, then saturation.
        qp_q    = {1'b0, r_acc[127:F]} + QW'(r_neg && (|r_acc[F-1:0]));
        qp_flag = 1'b0;
        if (!r_neg) begin
            if (qp_q > QW'(SMAX)) begin
                qp_flag = 1'b1;
                qp_res  = SMAX;
            end else begin
                qp_res = qp_q[SW-1:0];
            end
        end else begin
            if (qp_q > QW'(SMIN)) begin
                qp_flag = 1'b1;
                qp_res  = SMIN;
            end else begin
                qp_res = SW'(-qp_q[SW-1:0]);
            end
        end

        wb_sat  = sat_add(r_t, r_q);
        acc_sat = sat_add(r_sum, r_t);

        ey       = -$signed({r_d3[SW-1], r_d3});
        ey_mag   = ey[SW] ? (SW+1)'(-ey) : ey;
        ed_trial = EW'(LN2_Q32) << r_qi;

        dn_rs = {r_dr, r_dq[31]};
        dn_ge = (dn_rs >= {1'b0, r_n});

        // Scale the series sum by 2^k into the output format.
        sc_sh   = r_k - 8'(32 - F);
        sc_nsh  = 8'(-sc_sh);
        sc_v    = 64'(r_esum) << sc_sh[4:0];
        sc_flag = 1'b0;
        sc_e    = '0;
        if (!sc_sh[7]) begin
            if (sc_sh > 8'sd30 || sc_v > 64'(SMAX)) begin
                sc_flag = 1'b1;
                sc_e    = SMAX;
            end else begin
                sc_e = sc_v[SW-1:0];
            end
        end else if (sc_nsh < 8'd64) begin
            sc_e = SW'(64'(r_esum) >> sc_nsh[5:0]);
        end
    end

    // The molecule result enters the output register when it is free or
    // being taken in this cycle.
    assign out_load   = (r_state == B_ACC) && r_job.last_bond &&
                        (!r_out_valid || !i_stall);

    assign o_job_pop  = (r_state == B_IDLE) && i_job_valid;
    assign o_valid    = r_out_valid;
    assign o_energy   = r_out_energy;
    assign o_overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_ret       <= B_IDLE;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_sflag     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job    <= i_job;
                        r_rad    <= '0;
                        r_sq_idx <= '0;
                        r_sflag  <= 1'b0;
                        r_state  <= B_SQ_SET;
                    end
                end
                B_SQ_SET: begin
                    r_ma    <= 64'(sq_mag);
                    r_mb    <= 64'(sq_mag);
                    r_mc    <= '0;
                    r_acc   <= '0;
                    r_ret   <= B_SQ_ACC;
                    r_state <= B_MUL;
                end
                B_SQ_ACC: begin
                    r_rad <= r_rad + r_acc[65:0];
                    if (r_sq_idx == 2'd2) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 6'd32;
                        r_state <= B_SQRT;
                    end else begin
                        r_sq_idx <= r_sq_idx + 1'b1;
                        r_state  <= B_SQ_SET;
                    end
                end
                B_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (sq_rem_s >= sq_trial) begin
                        r_rem  <= sq_rem_s - sq_trial;
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem_s;
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_state <= B_DEV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                B_DEV: begin
                    r_d    <= SW'($signed(dev));
                    r_step <= '0;
                    r_t    <= '0;
                    if (r_job.form == bses_pkg::FORM_NONE) begin
                        r_state <= B_ACC;
                    end else begin
                        r_state <= B_OP;
                    end
                end
                B_OP: begin
                    r_ma    <= 64'(mag(op_a));
                    r_mb    <= 64'(mag(op_b));
                    r_neg   <= op_a[SW-1] ^ op_b[SW-1];
                    r_mc    <= '0;
                    r_acc   <= '0;
                    r_ret   <= B_QPOST;
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    if (r_mc != 3'd4) begin
                        r_pp <= mul_pp;
                        r_pi <= r_mc[1:0];
                    end
                    if (r_mc != 3'd0) begin
                        r_acc <= r_acc + mul_add;
                    end
                    if (r_mc == 3'd4) begin
                        r_state <= r_ret;
                    end
                    r_mc <= r_mc + 1'b1;
                end
                B_QPOST: begin
                    r_q <= qp_res;
                    if (qp_flag) begin
                        r_sflag <= 1'b1;
                    end
                    r_state <= B_WB;
                end
                B_WB: begin
                    case (cur_op.dst)
                        DST_D2:   r_d2 <= r_q;
                        DST_D3:   r_d3 <= r_q;
                        DST_D4:   r_d4 <= r_q;
                        DST_TSET: r_t  <= r_q;
                        default: begin
                            r_t <= wb_sat[SW-1:0];
                            if (wb_sat[SW]) begin
                                r_sflag <= 1'b1;
                            end
                        end
                    endcase
                    if (r_job.form == bses_pkg::FORM_MORSE && r_step == 3'd0) begin
                        r_state <= B_EXP_CHK;
                    end else if (cur_op.last) begin
                        r_state <= B_ACC;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= B_OP;
                    end
                end
                B_EXP_CHK: begin
                    if (ey > EXP_LIM) begin
                        r_e     <= SMAX;
                        r_sflag <= 1'b1;
                        r_state <= B_EXP_U;
                    end else if (ey < -EXP_LIM) begin
                        r_e     <= '0;
                        r_state <= B_EXP_U;
                    end else begin
                        r_yneg  <= ey[SW];
                        r_rm    <= EW'(ey_mag) << (32 - F);
                        r_qi    <= 3'd6;
                        r_qt    <= '0;
                        r_state <= B_EXP_DIV;
                    end
                end
                B_EXP_DIV: begin
                    if (r_rm >= ed_trial) begin
                        r_rm       <= r_rm - ed_trial;
                        r_qt[r_qi] <= 1'b1;
                    end
                    if (r_qi == 3'd0) begin
                        r_state <= B_EXP_FIX;
                    end else begin
                        r_qi <= r_qi - 1'b1;
                    end
                end
                B_EXP_FIX: begin
                    if (!r_yneg) begin
                        r_k <= $signed({1'b0, r_qt});
                        r_s <= r_rm[31:0];
                    end else if (r_rm == '0) begin
                        r_k <= -$signed({1'b0, r_qt});
                        r_s <= '0;
                    end else begin
                        r_k <= -$signed({1'b0, r_qt}) - 8'sd1;
                        r_s <= LN2_Q32 - r_rm[31:0];
                    end
                    r_term  <= 33'h1_0000_0000;
                    r_esum  <= 35'h1_0000_0000;
                    r_n     <= 4'd1;
                    r_state <= B_EXP_MUL;
                end
                B_EXP_MUL: begin
                    r_ma    <= 64'(r_term);
                    r_mb    <= 64'(r_s);
                    r_mc    <= '0;
                    r_acc   <= '0;
                    r_ret   <= B_EXP_DSET;
                    r_state <= B_MUL;
                end
                B_EXP_DSET: begin
                    r_dq    <= r_acc[63:32];
                    r_dr    <= '0;
                    r_cnt   <= 6'd31;
                    r_state <= B_EXP_DN;
                end
                B_EXP_DN: begin
                    r_dr <= dn_ge ? 4'(dn_rs - {1'b0, r_n}) : dn_rs[3:0];
                    r_dq <= {r_dq[30:0], dn_ge};
                    if (r_cnt == '0) begin
                        r_state <= B_EXP_NEXT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                B_EXP_NEXT: begin
                    r_term <= 33'(r_dq);
                    r_esum <= r_esum + 35'(r_dq);
                    if (r_n == 4'd12) begin
                        r_state <= B_EXP_SCALE;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= B_EXP_MUL;
                    end
                end
                B_EXP_SCALE: begin
                    r_e <= sc_e;
                    if (sc_flag) begin
                        r_sflag <= 1'b1;
                    end
                    r_state <= B_EXP_U;
                end
                B_EXP_U: begin
                    r_d4    <= ONE - r_e;
                    r_step  <= r_step + 1'b1;
                    r_state <= B_OP;
                end
                B_ACC: begin
                    if (!r_job.last_bond) begin
                        r_sum   <= acc_sat[SW-1:0];
                        r_sat   <= r_sat | r_sflag | acc_sat[SW];
                        r_state <= B_IDLE;
                    end else if (out_load) begin
                        r_out_energy <= acc_sat[SW-1:0];
                        r_out_ovf    <= r_sat | r_sflag | acc_sat[SW];
                        r_sum        <= '0;
                        r_sat        <= 1'b0;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/bond_stretch_energy_sum_core.sv =====
`timescale 1ns / 1ps
// The back end works through one bond at a time with its single shared multiplier,
// its one-bit-per-cycle square root and its exponential series up to the twelfth
// order term; the two-entry queue takes new transfers meanwhile.
// Reset (synchronous, active low) empties the queue, clears the molecule sum
// and its overflow flag, and drops any pending result.
// ----------------------------------------------------------------------------
// Bond stretch energy sum: top level
// Sums the bond stretch energy of a molecule, one bond per transfer, and
// delivers the saturated sum and its overflow flag with the last bond.
// ----------------------------------------------------------------------------
module bond_stretch_energy_sum_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Bond input channel.
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_first_x,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_first_y,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_first_z,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_second_x,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_second_y,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_second_z,
    input  logic [1:0]                            i_potential_form,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_ref_length,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_coef_b,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_coef_c,
    input  logic signed [bses_pkg::COORD_W-1:0]   i_coef_d,
    input  logic                                  i_last_bond,
    // Result channel.
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [bses_pkg::SUM_WIDTH-1:0] o_stretch_energy,
    output logic                                  o_overflow
);

    // The front end only forms the separation magnitudes and classifies a bond; the
    // queue holds it until the back end, which does the rest of the arithmetic, is free to take it.
    bses_pkg::t_job front_job;
    bses_pkg::t_job queue_job;
    logic           front_push;
    logic           queue_full;
    logic           queue_valid;
    logic           back_pop;

    bses_front u_front (
        .i_valid          (i_valid),
        .i_first_x        (i_first_x),
        .i_first_y        (i_first_y),
        .i_first_z        (i_first_z),
        .i_second_x       (i_second_x),
        .i_second_y       (i_second_y),
        .i_second_z       (i_second_z),
        .i_potential_form (i_potential_form),
        .i_ref_length     (i_ref_length),
        .i_coef_b         (i_coef_b),
        .i_coef_c         (i_coef_c),
        .i_coef_d         (i_coef_d),
        .i_last_bond      (i_last_bond),
        .i_full           (queue_full),
        .o_push           (front_push),
        .o_job            (front_job)
    );

    // A full queue stalls the input channel.
    assign o_stall = queue_full;

    bses_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_job   (queue_job),
        .i_pop   (back_pop)
    );

    // The back end keeps the result in its own output register, so a
    // stalled result transfer does not hold up work on the next bond until
    // the next molecule's last bond is finished.
    bses_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (back_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_energy    (o_stretch_energy),
        .o_overflow  (o_overflow)
    );

endmodule

// ===== rtl/bses_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond stretch energy sum: port checker
// Concurrent checks on the top level's handshake and reset behavior.
// ----------------------------------------------------------------------------
module bses_check (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [bses_pkg::SUM_WIDTH-1:0] o_stretch_energy,
    input logic                                  o_overflow
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_stretch_energy) && $stable(o_overflow))
        else $error("result changed while stalled");

    // Reset leaves no pending result.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset empties the queue, so the input is not stalled right after it.
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind bond_stretch_energy_sum_core bses_check u_bses_check (.*);
